### rtl/bpst_pkg.sv
// Beam point and segment test: shared widths, vector types and arithmetic helpers.
// Used by every module of the block; depends on nothing.
package bpst_pkg;

  localparam int unsigned CW    = 16;
  localparam int unsigned DW    = CW + 1;
  localparam int unsigned PW    = 2 * DW;
  localparam int unsigned NW    = PW + 1;
  localparam int unsigned MW    = NW + DW;
  localparam int unsigned SW    = MW + 2;
  localparam int unsigned TW    = 32;
  localparam int unsigned CMPW  = SW + 1;
  localparam int unsigned REGW  = 3 * CW;
  localparam int unsigned NSIDE = 4;
  localparam int unsigned IDXW  = 3;

  localparam int unsigned IN_TDATA_W  = ((6 * CW + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam int unsigned SETTLE_W = 2;
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = SETTLE_W'(2);

  typedef enum logic [IDXW-1:0] {
    REG_APEX     = 3'd0,
    REG_CORNER_A = 3'd1,
    REG_CORNER_B = 3'd2,
    REG_CORNER_C = 3'd3,
    REG_CORNER_D = 3'd4,
    REG_TOL      = 3'd5
  } reg_idx_e;

  typedef logic [CW-1:0] coord_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } point_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
  } diff_t;

  typedef struct packed {
    logic signed [PW-1:0] yz;
    logic signed [PW-1:0] zy;
    logic signed [PW-1:0] zx;
    logic signed [PW-1:0] xz;
    logic signed [PW-1:0] xy;
    logic signed [PW-1:0] yx;
  } xprod_t;

  typedef struct packed {
    logic signed [NW-1:0] x;
    logic signed [NW-1:0] y;
    logic signed [NW-1:0] z;
  } normal_t;

  typedef struct packed {
    logic signed [MW-1:0] x;
    logic signed [MW-1:0] y;
    logic signed [MW-1:0] z;
  } mvec_t;

  typedef struct packed {
    normal_t [NSIDE-1:0] side;
    normal_t             far_n;
    point_t              apex;
    point_t              corner_a;
    logic [TW-1:0]       tol;
  } geom_t;

  function automatic diff_t sub_pt(point_t p, point_t o);
    diff_t r;
    r.x = $signed({p.x[CW-1], p.x}) - $signed({o.x[CW-1], o.x});
    r.y = $signed({p.y[CW-1], p.y}) - $signed({o.y[CW-1], o.y});
    r.z = $signed({p.z[CW-1], p.z}) - $signed({o.z[CW-1], o.z});
    return r;
  endfunction

  function automatic xprod_t xprod_of(diff_t u, diff_t v);
    xprod_t r;
    r.yz = PW'(u.y) * PW'(v.z);
    r.zy = PW'(u.z) * PW'(v.y);
    r.zx = PW'(u.z) * PW'(v.x);
    r.xz = PW'(u.x) * PW'(v.z);
    r.xy = PW'(u.x) * PW'(v.y);
    r.yx = PW'(u.y) * PW'(v.x);
    return r;
  endfunction

  function automatic normal_t norm_of(xprod_t p);
    normal_t r;
    r.x = NW'(p.yz) - NW'(p.zy);
    r.y = NW'(p.zx) - NW'(p.xz);
    r.z = NW'(p.xy) - NW'(p.yx);
    return r;
  endfunction

  function automatic mvec_t nmul(normal_t n, diff_t d);
    mvec_t r;
    r.x = MW'(n.x) * MW'(d.x);
    r.y = MW'(n.y) * MW'(d.y);
    r.z = MW'(n.z) * MW'(d.z);
    return r;
  endfunction

  function automatic logic signed [SW-1:0] vsum(mvec_t m);
    return SW'(m.x) + SW'(m.y) + SW'(m.z);
  endfunction

endpackage

### rtl/bpst_cfg.sv
// Beam configuration registers and face normal pipeline (products, then normals).
// Depends on bpst_pkg.
module bpst_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpst_pkg::IDXW-1:0]     cfg_idx_i,
  input  logic [bpst_pkg::REGW-1:0]     cfg_data_i,
  output bpst_pkg::geom_t               geom_o,
  output logic                          settled_o
);

  bpst_pkg::point_t              apex_q, a_q, b_q, c_q, d_q;
  logic [bpst_pkg::TW-1:0]       tol_q;
  logic [bpst_pkg::SETTLE_W-1:0] settle_q, settle_d;

  bpst_pkg::diff_t  ea, eb, ec, ed, fb, fd;
  bpst_pkg::xprod_t [bpst_pkg::NSIDE:0] xp_d, xp_q;
  bpst_pkg::normal_t [bpst_pkg::NSIDE:0] nrm_d, nrm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      apex_q <= '0;
      a_q    <= '0;
      b_q    <= '0;
      c_q    <= '0;
      d_q    <= '0;
      tol_q  <= '0;
    end else if (cfg_we_i) begin
      case (bpst_pkg::reg_idx_e'(cfg_idx_i))
        bpst_pkg::REG_APEX:     apex_q <= cfg_data_i;
        bpst_pkg::REG_CORNER_A: a_q    <= cfg_data_i;
        bpst_pkg::REG_CORNER_B: b_q    <= cfg_data_i;
        bpst_pkg::REG_CORNER_C: c_q    <= cfg_data_i;
        bpst_pkg::REG_CORNER_D: d_q    <= cfg_data_i;
        bpst_pkg::REG_TOL:      tol_q  <= cfg_data_i[bpst_pkg::TW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    settle_d = settle_q;
    if (cfg_we_i) begin
      settle_d = bpst_pkg::SETTLE_CYCLES;
    end else if (settle_q != '0) begin
      settle_d = settle_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= bpst_pkg::SETTLE_CYCLES;
    end else begin
      settle_q <= settle_d;
    end
  end

  always_comb begin
    ea = bpst_pkg::sub_pt(a_q, apex_q);
    eb = bpst_pkg::sub_pt(b_q, apex_q);
    ec = bpst_pkg::sub_pt(c_q, apex_q);
    ed = bpst_pkg::sub_pt(d_q, apex_q);
    fb = bpst_pkg::sub_pt(b_q, a_q);
    fd = bpst_pkg::sub_pt(d_q, a_q);
    xp_d[0] = bpst_pkg::xprod_of(ea, ed);
    xp_d[1] = bpst_pkg::xprod_of(eb, ea);
    xp_d[2] = bpst_pkg::xprod_of(ec, eb);
    xp_d[3] = bpst_pkg::xprod_of(ed, ec);
    xp_d[bpst_pkg::NSIDE] = bpst_pkg::xprod_of(fb, fd);
    for (int i = 0; i <= bpst_pkg::NSIDE; i++) begin
      nrm_d[i] = bpst_pkg::norm_of(xp_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    xp_q  <= xp_d;
    nrm_q <= nrm_d;
  end

  always_comb begin
    geom_o.side     = nrm_q[bpst_pkg::NSIDE-1:0];
    geom_o.far_n    = nrm_q[bpst_pkg::NSIDE];
    geom_o.apex     = apex_q;
    geom_o.corner_a = a_q;
    geom_o.tol      = tol_q;
  end

  assign settled_o = (settle_q == '0);

endmodule

### rtl/bpst_pipe.sv
// Item pipeline: offsets, dot products, sums, half-space compares, result register.
// Depends on bpst_pkg; takes beam geometry from bpst_cfg.
module bpst_pipe (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bpst_pkg::geom_t         geom_i,
  input  logic                    settled_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    op_i,
  input  bpst_pkg::point_t        p_i,
  input  bpst_pkg::point_t        q_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    hit_o
);

  localparam int unsigned NS = bpst_pkg::NSIDE;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic ld1, ld2, ld3, ld4, ld5;

  logic            op1_q, op2_q, op3_q, op4_q;
  bpst_pkg::diff_t dpa_q, dqa_q, dpf_q;

  bpst_pkg::mvec_t [NS-1:0] mp_d, mp_q, mq_d, mq_q;
  bpst_pkg::mvec_t          mf_d, mf_q;

  logic signed [bpst_pkg::SW-1:0] sp_d [NS];
  logic signed [bpst_pkg::SW-1:0] sp_q [NS];
  logic signed [bpst_pkg::SW-1:0] sq_d [NS];
  logic signed [bpst_pkg::SW-1:0] sq_q [NS];
  logic signed [bpst_pkg::SW-1:0] sf_q;

  logic [bpst_pkg::CMPW-1:0] tol_w;
  logic [bpst_pkg::CMPW-1:0] in_sum [NS];
  logic [bpst_pkg::CMPW-1:0] out_p_sum [NS];
  logic [bpst_pkg::CMPW-1:0] out_q_sum [NS];
  logic [bpst_pkg::CMPW-1:0] far_sum;

  logic [NS-1:0] in_p_d, in_p_q, out_p_d, out_p_q, out_q_d, out_q_q;
  logic          in_f_d, in_f_q;
  logic          hit_d, hit_q;

  assign ld5 = !v5_q || out_ready_i;
  assign ld4 = !v4_q || ld5;
  assign ld3 = !v3_q || ld4;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;

  assign in_ready_o = ld1 && settled_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= in_valid_i && settled_i;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
      if (ld4) v4_q <= v3_q;
      if (ld5) v5_q <= v4_q;
    end
  end

  // offsets from the face origins
  always_ff @(posedge clk_i) begin
    if (ld1) begin
      op1_q <= op_i;
      dpa_q <= bpst_pkg::sub_pt(p_i, geom_i.apex);
      dqa_q <= bpst_pkg::sub_pt(q_i, geom_i.apex);
      dpf_q <= bpst_pkg::sub_pt(p_i, geom_i.corner_a);
    end
  end

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      mp_d[i] = bpst_pkg::nmul(geom_i.side[i], dpa_q);
      mq_d[i] = bpst_pkg::nmul(geom_i.side[i], dqa_q);
    end
    mf_d = bpst_pkg::nmul(geom_i.far_n, dpf_q);
  end

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      op2_q <= op1_q;
      mp_q  <= mp_d;
      mq_q  <= mq_d;
      mf_q  <= mf_d;
    end
  end

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      sp_d[i] = bpst_pkg::vsum(mp_q[i]);
      sq_d[i] = bpst_pkg::vsum(mq_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      op3_q <= op2_q;
      sp_q  <= sp_d;
      sq_q  <= sq_d;
      sf_q  <= bpst_pkg::vsum(mf_q);
    end
  end

  // inside: dot + tol >= 0; outside: tol - dot >= 0
  always_comb begin
    tol_w = bpst_pkg::CMPW'(geom_i.tol);
    for (int i = 0; i < NS; i++) begin
      in_sum[i]    = bpst_pkg::CMPW'(sp_q[i]) + tol_w;
      out_p_sum[i] = tol_w - bpst_pkg::CMPW'(sp_q[i]);
      out_q_sum[i] = tol_w - bpst_pkg::CMPW'(sq_q[i]);
      in_p_d[i]    = !in_sum[i][bpst_pkg::CMPW-1];
      out_p_d[i]   = !out_p_sum[i][bpst_pkg::CMPW-1];
      out_q_d[i]   = !out_q_sum[i][bpst_pkg::CMPW-1];
    end
    far_sum = bpst_pkg::CMPW'(sf_q) + tol_w;
    in_f_d  = !far_sum[bpst_pkg::CMPW-1];
  end

  always_ff @(posedge clk_i) begin
    if (ld4) begin
      op4_q   <= op3_q;
      in_p_q  <= in_p_d;
      in_f_q  <= in_f_d;
      out_p_q <= out_p_d;
      out_q_q <= out_q_d;
    end
  end

  always_comb begin
    if (op4_q) begin
      hit_d = !(|(out_p_q & out_q_q));
    end else begin
      hit_d = (&in_p_q) && in_f_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld5) begin
      hit_q <= hit_d;
    end
  end

  assign out_valid_o = v5_q;
  assign hit_o       = hit_q;

endmodule

### rtl/beam_point_and_segment_test.sv
// Beam point and segment test, top level: stream ports, config port, packing.
// An accepted input beat passes the offset, product, sum, compare and result registers to its
// result beat; one beat per cycle while the output is not stalled and the normals are settled.
// Each stage holds its own valid bit, so bubbles close up under an output stall. Reset clears
// the pipeline valid bits and the config registers to zero; input ready stays low after reset
// and after every config write while the face normals recompute. Depends on bpst_pkg, bpst_cfg and bpst_pipe.
module beam_point_and_segment_test (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bpst_pkg::IDXW-1:0]          cfg_idx_i,
  input  logic [bpst_pkg::REGW-1:0]          cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // point_x, point_y, point_z, end_x, end_y, end_z
  input  logic [bpst_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // op
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // hit, zero fill
  output logic [bpst_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  bpst_pkg::geom_t  geom;
  logic             settled;
  bpst_pkg::point_t p_in, q_in;
  logic             hit;

  assign p_in = bpst_pkg::point_t'(s_axis_tdata[3*bpst_pkg::CW-1:0]);
  assign q_in = bpst_pkg::point_t'(s_axis_tdata[6*bpst_pkg::CW-1:3*bpst_pkg::CW]);

  bpst_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .geom_o     (geom),
    .settled_o  (settled)
  );

  bpst_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .settled_i   (settled),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .p_i         (p_in),
    .q_i         (q_in),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .hit_o       (hit)
  );

  assign m_axis_tdata = {(bpst_pkg::OUT_TDATA_W-1)'(0), hit};

endmodule

### rtl/bpst_checker.sv
// Port-level checker for the beam point and segment test, bound to the top level.
// Depends on bpst_pkg.
module bpst_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_we_i,
  input logic [bpst_pkg::IDXW-1:0]          cfg_idx_i,
  input logic [bpst_pkg::REGW-1:0]          cfg_data_i,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [bpst_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input logic                               s_axis_tuser,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [bpst_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed under stall");

  // block input while normals recompute
  a_cfg_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken before normals settled");

  a_out_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[bpst_pkg::OUT_TDATA_W-1:1] == '0)
    else $error("result fill bits not zero");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid && !s_axis_tready)
    else $error("handshake active during reset");

endmodule

bind beam_point_and_segment_test bpst_checker u_checker (.*);
